// File: design/mjdfr_pkg.sv
// shared types, constants and the header text table for the mjpeg deframer
package mjdfr_pkg;

   localparam int LENGTH_BITS_DEF = 24;

   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] BYTE_SOI = 8'hD8;
   localparam logic [7:0] BYTE_EOI = 8'hD9;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // "Content-Length: " is 16 characters
   localparam int MATCH_W = 4;

   // response queue depth
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef enum logic {
      MODE_HEADER,
      MODE_BODY
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       ok;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic logic [7:0] hdr_char(input logic [MATCH_W-1:0] idx);
      logic [7:0] c;
      c = 8'h20;
      unique case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h4C; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         4'd15:   c = 8'h20; // space
         default: c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

// File: design/mjpeg_multipart_deframer.sv
// top level of the mjpeg multipart deframer: input register, parser core, response queue
//
// channel   direction  tdata              tuser      tlast
// req_      in         data_byte[7:0]     -          -
// rsp_      out        out_byte[7:0]      frame_ok   frame_last
//
// one stream byte per cycle while rsp_ keeps up; each byte is held in the input
// register and parsed by the core as it leaves it; the results go to the response queue
// the start marker ff d8 after a usable length yields two results in one step, queued in a four-entry fifo
// the core steps only when the fifo has room for two items, so a stalled rsp_ side
// backs up into the input register and then req_tready
// reset is synchronous and active high and puts the block in header mode
module mjpeg_multipart_deframer
   import mjdfr_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   // byte stream in
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   // jpeg bytes out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // frame_last
   output logic       rsp_tuser    // [0] frame_ok
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         room;
   logic         step;
   push_type     push;
   rsp_item_type rsp_item;

   // input register drains whenever the core can step
   assign step        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   mjdfr_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .push      (push)
   );

   mjdfr_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // queue entry onto the result channel
   assign rsp_tdata = rsp_item.data;
   assign rsp_tlast = rsp_item.last;
   assign rsp_tuser = rsp_item.ok;

endmodule

// File: design/mjdfr_rsp_fifo.sv
// small response queue taking up to two items per cycle and giving one
module mjdfr_rsp_fifo
   import mjdfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         room,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   rsp_item_type mem [FIFO_DEPTH];

   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;
   logic [FIFO_AW-1:0] wr_ptr_nx;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_item   = mem[rd_ptr_ff];
   // room for a two-item push regardless of pop
   assign room       = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign wr_ptr_nx  = wr_ptr_ff + FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_nx] <= push.item1;
      end
   end

endmodule

// File: design/mjdfr_core.sv
// header parsing, marker detection and body byte counting, one byte per step
module mjdfr_core
   import mjdfr_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   output push_type   push
);

   localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

   mode_type                mode_ff, mode_in;
   logic [7:0]              prev_ff;
   logic [MATCH_W-1:0]      match_ff, match_in;
   logic                    coll_ff, coll_in;
   logic                    lvalid_ff, lvalid_in;
   logic                    broken_ff, broken_in;
   logic [LENGTH_BITS-1:0]  flen_ff, flen_in;
   logic [LENGTH_BITS-1:0]  fwd_ff, fwd_in;

   logic                    is_soi, is_eol, is_digit, usable;
   logic [LENGTH_BITS-1:0]  fwd_inc;
   logic                    body_end;
   logic [LENGTH_BITS+3:0]  digit_sum;
   logic                    digit_ovf;
   logic [MATCH_W:0]        match_nx;

   assign is_soi   = (prev_ff == BYTE_FF) && (data_byte == BYTE_SOI);
   assign is_eol   = (data_byte == CH_CR) || (data_byte == CH_LF);
   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign usable   = lvalid_ff && (flen_ff >= LEN_TWO);
   assign fwd_inc  = fwd_ff + LENGTH_BITS'(1);
   assign body_end = (fwd_inc == flen_ff);

   // length * 10 + digit, with four spare bits to see overflow
   assign digit_sum = ({4'b0, flen_ff} << 3) + ({4'b0, flen_ff} << 1)
                    + (LENGTH_BITS+4)'(data_byte[3:0]);
   assign digit_ovf = (digit_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'b0);

   always_comb begin
      if (data_byte == hdr_char(match_ff)) begin
         match_nx = {1'b0, match_ff} + (MATCH_W+1)'(1);
      end else if (data_byte == hdr_char('0)) begin
         match_nx = (MATCH_W+1)'(1);
      end else begin
         match_nx = '0;
      end
   end

   // mode transitions
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_HEADER: begin
            if (is_soi && usable && (flen_ff != LEN_TWO)) begin
               mode_in = MODE_BODY;
            end
         end
         MODE_BODY: begin
            if (body_end) begin
               mode_in = MODE_HEADER;
            end
         end
         default: mode_in = MODE_HEADER;
      endcase
   end

   // datapath and results
   always_comb begin
      match_in   = match_ff;
      coll_in    = coll_ff;
      lvalid_in  = lvalid_ff;
      broken_in  = broken_ff;
      flen_in    = flen_ff;
      fwd_in     = fwd_ff;
      push.count = 2'd0;
      push.item0 = '{data: data_byte, last: 1'b0, ok: 1'b0};
      push.item1 = '{data: BYTE_SOI, last: 1'b0, ok: 1'b0};
      unique case (mode_ff)
         MODE_BODY: begin
            push.count = 2'd1;
            fwd_in     = fwd_inc;
            if (body_end) begin
               push.item0.last = 1'b1;
               push.item0.ok   = (prev_ff == BYTE_FF) && (data_byte == BYTE_EOI);
               fwd_in    = '0;
               match_in  = '0;
               coll_in   = 1'b0;
               lvalid_in = 1'b0;
               broken_in = 1'b0;
               flen_in   = '0;
            end
         end
         MODE_HEADER: begin
            if (is_soi) begin
               match_in  = '0;
               coll_in   = 1'b0;
               broken_in = 1'b0;
               if (usable) begin
                  push.count = 2'd2;
                  push.item0 = '{data: BYTE_FF, last: 1'b0, ok: 1'b0};
                  if (flen_ff == LEN_TWO) begin
                     push.item1.last = 1'b1;
                     lvalid_in = 1'b0;
                     flen_in   = '0;
                  end else begin
                     fwd_in = LEN_TWO;
                  end
               end else begin
                  lvalid_in = 1'b0;
                  flen_in   = '0;
               end
            end else if (is_eol) begin
               coll_in  = 1'b0;
               match_in = '0;
            end else if (coll_ff) begin
               if (!broken_ff) begin
                  if (is_digit && !digit_ovf) begin
                     flen_in   = digit_sum[LENGTH_BITS-1:0];
                     lvalid_in = 1'b1;
                  end else begin
                     broken_in = 1'b1;
                     lvalid_in = 1'b0;
                  end
               end
            end else if (match_nx[MATCH_W]) begin
               // whole header name seen, length text follows
               match_in  = '0;
               coll_in   = 1'b1;
               lvalid_in = 1'b0;
               broken_in = 1'b0;
               flen_in   = '0;
            end else begin
               match_in = match_nx[MATCH_W-1:0];
            end
         end
         default: ;
      endcase
      if (!step) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HEADER;
         prev_ff   <= '0;
         match_ff  <= '0;
         coll_ff   <= 1'b0;
         lvalid_ff <= 1'b0;
         broken_ff <= 1'b0;
         flen_ff   <= '0;
         fwd_ff    <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         prev_ff   <= data_byte;
         match_ff  <= match_in;
         coll_ff   <= coll_in;
         lvalid_ff <= lvalid_in;
         broken_ff <= broken_in;
         flen_ff   <= flen_in;
         fwd_ff    <= fwd_in;
      end
   end

endmodule
